// File: design/pdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_pkg
// Shared widths, codes and control types of the pump duty timer.
// ----------------------------------------------------------------------------
package pdt_pkg;

  localparam int TIME_BITS = 32;
  localparam int RATE_BITS = 24;
  localparam int CNT_W     = $clog2(TIME_BITS);

  typedef enum logic [2:0] {
    CFG_PERIOD     = 3'd0,
    CFG_SHUTOFF    = 3'd1,
    CFG_LOWER      = 3'd2,
    CFG_UPPER      = 3'd3,
    CFG_ACTIVE_LOW = 3'd4
  } pdt_cfg_idx_t;

  typedef enum logic [1:0] {
    LVL_OK   = 2'd0,
    LVL_WARN = 2'd1,
    LVL_ERR  = 2'd2
  } pdt_lvl_t;

  typedef enum logic [1:0] {
    CODE_OK    = 2'd0,
    CODE_STALE = 2'd1,
    CODE_LOW   = 2'd2,
    CODE_HIGH  = 2'd3
  } pdt_code_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCALE,
    ST_DONE
  } pdt_state_t;

  typedef struct packed {
    logic tick;
    logic set_now;
    logic start;
    logic div_step;
    logic scale_step;
    logic finish;
  } pdt_cmd_t;

  typedef struct packed {
    logic set_quick;
    logic cnt_zero;
    logic pump_on;
    logic stale;
  } pdt_stat_t;

endpackage

// File: design/pdt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_ctrl
// Controller: input/output handshake and sequencing of the rate scaler.
// ----------------------------------------------------------------------------
module pdt_ctrl
  import pdt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_mode,
  output logic      out_valid,
  input  logic      out_ready,
  input  pdt_stat_t stat,
  output pdt_cmd_t  cmd
);

  pdt_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = out_free;
        if (in_valid && out_free) begin
          if (!in_mode) begin
            cmd.tick      = 1'b1;
            out_valid_nxt = 1'b1;
          end else if (stat.set_quick) begin
            cmd.set_now   = 1'b1;
            out_valid_nxt = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.cnt_zero) state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.scale_step = 1'b1;
        if (stat.cnt_zero) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// File: design/pdt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdt_dp
// Datapath: registers, schedule and watchdog logic, serial divide and scale.
// ----------------------------------------------------------------------------
module pdt_dp
  import pdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [RATE_BITS-1:0] in_rate,
  input  pdt_cmd_t             cmd,
  output pdt_stat_t            stat,
  output logic                 pump_pin,
  output logic [1:0]           alarm_level,
  output logic [1:0]           alarm_code
);

  logic [TIME_BITS-1:0] period_r, shutoff_r;
  logic [RATE_BITS-1:0] lower_r, upper_r;
  logic                 active_low_r;

  logic [TIME_BITS-1:0] now_r, last_cmd_r, last_sw_r, on_r, off_r;
  logic                 pump_on_r, stale_r;
  pdt_lvl_t             level_r;
  pdt_code_t            code_r;

  logic [TIME_BITS-1:0] div_r, div_nxt;
  logic [RATE_BITS-1:0] drem_r, drem_nxt;
  logic [TIME_BITS-1:0] acc_r, acc_nxt;
  logic [RATE_BITS-1:0] arem_r, arem_nxt;
  logic [RATE_BITS-1:0] rate_r;
  logic [CNT_W-1:0]     cnt_r;

  // tick decisions
  logic [TIME_BITS-1:0] now1, el_cmd, el_sw;
  logic                 stale_hit, sw_off, sw_on;
  // set checks
  logic                 bad_lo, bad_hi, rate_zero;
  // divide step
  logic [RATE_BITS:0]   d_rs;
  logic                 d_c;
  // scale step
  logic [RATE_BITS:0]   s_rs, s_ra;
  logic [RATE_BITS-1:0] s_r1;
  logic                 s_c1, s_c2, s_bit;

  assign now1      = now_r + 1'b1;
  assign el_cmd    = now1 - last_cmd_r;
  assign el_sw     = now1 - last_sw_r;
  assign stale_hit = pump_on_r && (el_cmd > shutoff_r);
  assign sw_off    = pump_on_r && (el_sw > on_r);
  assign sw_on     = !pump_on_r && (el_sw > off_r) && (on_r != '0);

  assign rate_zero = (in_rate == '0);
  assign bad_lo    = !rate_zero && (in_rate < lower_r);
  assign bad_hi    = in_rate > upper_r;

  assign stat.set_quick = bad_lo || bad_hi || rate_zero;
  assign stat.cnt_zero  = (cnt_r == '0);
  assign stat.pump_on   = pump_on_r;
  assign stat.stale     = stale_r;

  assign pump_pin    = pump_on_r ^ active_low_r;
  assign alarm_level = level_r;
  assign alarm_code  = code_r;

  always_comb begin
    d_rs     = {drem_r, div_r[TIME_BITS-1]};
    d_c      = d_rs >= {1'b0, upper_r};
    drem_nxt = d_c ? RATE_BITS'(d_rs - {1'b0, upper_r}) : d_rs[RATE_BITS-1:0];
    div_nxt  = {div_r[TIME_BITS-2:0], d_c};
  end

  always_comb begin
    s_bit    = rate_r[RATE_BITS-1];
    s_rs     = {arem_r, 1'b0};
    s_c1     = s_rs >= {1'b0, upper_r};
    s_r1     = s_c1 ? RATE_BITS'(s_rs - {1'b0, upper_r}) : s_rs[RATE_BITS-1:0];
    s_ra     = {1'b0, s_r1} + {1'b0, drem_r};
    s_c2     = s_bit && (s_ra >= {1'b0, upper_r});
    arem_nxt = !s_bit ? s_r1
             : (s_c2 ? RATE_BITS'(s_ra - {1'b0, upper_r}) : s_ra[RATE_BITS-1:0]);
    acc_nxt  = {acc_r[TIME_BITS-2:0], s_c1}
             + (s_bit ? (div_r + {{(TIME_BITS-1){1'b0}}, s_c2}) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r     <= TIME_BITS'(60000);
      shutoff_r    <= TIME_BITS'(300000);
      lower_r      <= '0;
      upper_r      <= '1;
      active_low_r <= 1'b0;
    end else if (cfg_valid) begin
      case (pdt_cfg_idx_t'(cfg_index))
        CFG_PERIOD:     period_r     <= cfg_data[TIME_BITS-1:0];
        CFG_SHUTOFF:    shutoff_r    <= cfg_data[TIME_BITS-1:0];
        CFG_LOWER:      lower_r      <= cfg_data[RATE_BITS-1:0];
        CFG_UPPER:      upper_r      <= cfg_data[RATE_BITS-1:0];
        CFG_ACTIVE_LOW: active_low_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r      <= '0;
      last_cmd_r <= '0;
      last_sw_r  <= '0;
      on_r       <= '0;
      off_r      <= '0;
      pump_on_r  <= 1'b0;
      stale_r    <= 1'b0;
      level_r    <= LVL_OK;
      code_r     <= CODE_OK;
    end else if (cmd.tick) begin
      now_r <= now1;
      if (stale_hit) begin
        pump_on_r <= 1'b0;
        stale_r   <= 1'b1;
        level_r   <= LVL_WARN;
        code_r    <= CODE_STALE;
      end else if (stale_r) begin
        pump_on_r <= 1'b0;
      end else if (sw_off || sw_on) begin
        pump_on_r <= sw_on;
        last_sw_r <= now1;
      end
    end else if (cmd.set_now) begin
      if (bad_lo) begin
        level_r <= LVL_ERR;
        code_r  <= CODE_LOW;
      end else if (bad_hi) begin
        level_r <= LVL_ERR;
        code_r  <= CODE_HIGH;
      end else begin
        on_r       <= '0;
        off_r      <= period_r;
        last_cmd_r <= now_r;
        stale_r    <= 1'b0;
        level_r    <= LVL_OK;
        code_r     <= CODE_OK;
      end
    end else if (cmd.finish) begin
      on_r       <= acc_r;
      off_r      <= period_r - acc_r;
      last_cmd_r <= now_r;
      stale_r    <= 1'b0;
      level_r    <= LVL_OK;
      code_r     <= CODE_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      div_r  <= period_r;
      drem_r <= '0;
      acc_r  <= '0;
      arem_r <= '0;
      rate_r <= in_rate;
      cnt_r  <= CNT_W'(TIME_BITS - 1);
    end else if (cmd.div_step) begin
      div_r  <= div_nxt;
      drem_r <= drem_nxt;
      cnt_r  <= stat.cnt_zero ? CNT_W'(RATE_BITS - 1) : cnt_r - 1'b1;
    end else if (cmd.scale_step) begin
      acc_r  <= acc_nxt;
      arem_r <= arem_nxt;
      rate_r <= {rate_r[RATE_BITS-2:0], 1'b0};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

endmodule

// File: design/pump_duty_timer_with_watchdog_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pump_duty_timer_with_watchdog_core
// Time-proportioned pump driver with a stale-command watchdog.
// ----------------------------------------------------------------------------
// Channel  Direction  Ports
// in       input      in_valid, in_ready, in_mode, in_rate
// out      output     out_valid, out_ready, out_pump_pin, out_alarm_level,
//                     out_alarm_code
// cfg      input      cfg_valid, cfg_ready, cfg_index, cfg_data
//
// Tick word and rejected or zero-rate set word: result registered, valid in the cycle after accept.
// Accepted nonzero set word: a 32-step divide of the period by the upper
// bound, a 24-step scale over the rate bits, then a commit once out is free.
// One word in flight; the next word is taken as the previous result leaves.
// Synchronous active-low reset; cfg writes complete every cycle.
// ----------------------------------------------------------------------------
module pump_duty_timer_with_watchdog_core
  import pdt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic [RATE_BITS-1:0] in_rate,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_pump_pin,
  output logic [1:0]           out_alarm_level,
  output logic [1:0]           out_alarm_code,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);

  pdt_cmd_t  cmd;
  pdt_stat_t stat;

  assign cfg_ready = 1'b1;

  pdt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pdt_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_rate     (in_rate),
    .cmd         (cmd),
    .stat        (stat),
    .pump_pin    (out_pump_pin),
    .alarm_level (out_alarm_level),
    .alarm_code  (out_alarm_code)
  );

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.scale_step) |-> !in_ready)
    else $error("word accepted while scaler busy");

  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_mode) |=> out_valid)
    else $error("tick word gave no result");

  a_stale_off: assert property (@(posedge clk) disable iff (!rst_n)
    stat.stale |-> !stat.pump_on)
    else $error("pump on during stale stop");

  a_alarm_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_alarm_level == LVL_OK) == (out_alarm_code == CODE_OK))
    else $error("alarm level and code disagree");

endmodule
